FILE: src/folded_substring_search_top_macros.svh
// Assertion macros used by the checker file of the folded substring search.
// Depends on a clock and a reset signal in the scope that uses them.
`ifndef FOLDED_SUBSTRING_SEARCH_TOP_MACROS_SVH
`define FOLDED_SUBSTRING_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define FSS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define FSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also runs through reset.
`define FSS_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/fss_pkg.sv
// Types, constants and byte helpers for the folded substring search.
// No dependencies; used by every other file of the block but the assertion macros header.
`default_nettype none

package fss_pkg;

   // Field widths
   localparam int LEN_W    = 7;
   localparam int QIDX_W   = 6;
   localparam int OFFSET_W = 32;
   localparam int COUNT_W  = 16;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int               MAX_QUERY_BYTES_DEFAULT = 64;
   localparam logic [COUNT_W-1:0] MATCH_LIMIT_RESET     = 16'd1024;

   // Result queue
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int QPTR_W          = 2;
   localparam int QCNT_W          = 3;

   // Byte classes
   localparam logic [7:0] CONT_LO      = 8'h80;
   localparam logic [7:0] CONT_HI      = 8'hBF;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0,
      REQ_DOC  = 2'd1,
      REQ_END  = 2'd2
   } req_kind_type;

   typedef enum logic {
      REG_QUERY_LENGTH = 1'b0,
      REG_MATCH_LIMIT  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] match_start;
      logic [OFFSET_W-1:0] match_end;
      logic                is_summary;
      logic                truncated;
      logic [COUNT_W-1:0]  match_total;
      logic                last_result;
   } result_type;

   // Words pushed into the result queue for one accepted request
   typedef struct packed {
      logic [1:0] count;
      result_type w0;
      result_type w1;
   } push_type;

   // Broadcast from the controller to every cell of the row
   typedef struct packed {
      logic              load;
      logic [QIDX_W-1:0] load_index;
      logic [7:0]        load_byte;
      logic              step;
      logic              flush;
      logic              clear;
      logic [7:0]        doc_folded;
      logic              start;
      logic [LEN_W-1:0]  len;
   } cell_bus_type;

   // ASCII upper case to lower case, everything else untouched
   function automatic logic [7:0] fold_byte(input logic [7:0] b);
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         return b + CASE_OFFSET;
      end
      return b;
   endfunction

   // UTF-8 continuation byte
   function automatic logic is_cont(input logic [7:0] b);
      return (b >= CONT_LO) && (b <= CONT_HI);
   endfunction

endpackage

`default_nettype wire

FILE: src/fss_channels.sv
// Valid/ready channel interfaces for request and result words.
// Depends on fss_pkg.
`default_nettype none

interface fss_req_if import fss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [QIDX_W-1:0] query_index;
   logic [7:0]        data_byte;

   modport source (output valid, req_type, query_index, data_byte, input ready);
   modport sink   (input valid, req_type, query_index, data_byte, output ready);
endinterface

interface fss_rsp_if import fss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] match_start;
   logic [OFFSET_W-1:0] match_end;
   logic                is_summary;
   logic                truncated;
   logic [COUNT_W-1:0]  match_total;
   logic                last_result;

   modport source (output valid, match_start, match_end, is_summary, truncated,
                   match_total, last_result, input ready);
   modport sink   (input valid, match_start, match_end, is_summary, truncated,
                   match_total, last_result, output ready);
endinterface

`default_nettype wire

FILE: src/fss_cell.sv
// One query position: folded query byte and its prefix-match bit.
// Depends on fss_pkg.
`default_nettype none

module fss_cell import fss_pkg::*; #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_bus_type bus,
   input  wire logic         chain_in,
   output logic              prefix_out,
   output logic              prefix_next
);

   logic [7:0] q_ff;
   logic       prefix_ff;
   logic       prefix_in;
   logic       in_use;

   // Query byte, stored folded; no reset, so the user must load it before use; the cell does not enforce this
   always_ff @(posedge clock) begin
      if (bus.load && bus.load_index == QIDX_W'(CELL_INDEX)) begin
         q_ff <= fold_byte(bus.load_byte);
      end
   end

   // Prefix of length CELL_INDEX+1 ends at this byte
   assign in_use      = bus.len > LEN_W'(CELL_INDEX);
   assign prefix_next = chain_in & in_use & (q_ff == bus.doc_folded);

   always_comb begin
      prefix_in = prefix_ff;
      if (bus.clear) begin
         prefix_in = 1'b0;
      end else if (bus.step) begin
         prefix_in = prefix_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
      end
   end

   assign prefix_out = prefix_ff;

endmodule

`default_nettype wire

FILE: src/fss_out_queue.sv
// Four-word result queue; takes up to two words per cycle, gives one.
// Depends on fss_pkg.
`default_nettype none

module fss_out_queue import fss_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push_in,
   input  wire logic     pop,
   output result_type    head,
   output logic          not_empty,
   output logic          has_room
);

   result_type        entry_ff [RSP_QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign do_pop = pop && (count_ff != '0);

   // Storage
   always_ff @(posedge clock) begin
      if (push_in.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_in.w0;
      end
      if (push_in.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 1'b1] <= push_in.w1;
      end
   end

   // Pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_in.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(do_pop);
      count_in  = count_ff + QCNT_W'(push_in.count) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign has_room  = count_ff <= QCNT_W'(RSP_QUEUE_DEPTH - 2);

endmodule

`default_nettype wire

FILE: src/folded_substring_search_top.sv
// Folded substring search: controller, configuration registers, cell row, result queue.
// Depends on fss_pkg, fss_channels, fss_cell and fss_out_queue.
//
// Usage: load query bytes with request words of type load (query_index, data_byte),
// set query_length (and match_limit) over the APB port while idle, then stream
// document bytes with type doc and close each document with type end. Type 3 is dropped.
// Each document byte is compared against all query positions at once in a row of
// MAX_QUERY_BYTES cells that shift the prefix-match bits one position per byte.
// Throughput: one request word per cycle while req.ready is high; a load or doc word
// yields at most one result word, an end word up to two (pending match, then summary),
// so a run of end words is bounded by the one-word-per-cycle result port.
// A result word is registered into the result queue when the request word that decides
// it is taken. A match is decided by the byte after it or by end of document.
// The result port is buffered by a four-word queue; req.ready drops when fewer than
// two slots are free, so a stalled receiver backs up into the request channel
// without losing words. Reset (synchronous) empties the queue, clears the search
// state and sets query_length to 0 and match_limit to 1024; query bytes keep no
// reset value and must be loaded before use.
`default_nettype none

module folded_substring_search_top import fss_pkg::*; #(
   parameter int MAX_QUERY_BYTES = MAX_QUERY_BYTES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   fss_req_if.sink                    req_if,
   fss_rsp_if.source                  rsp_if,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   // Configuration registers
   logic [LEN_W-1:0]   qlen_ff;
   logic [COUNT_W-1:0] limit_ff;
   logic               csr_write;
   reg_index_type      csr_reg;

   // Search state
   logic                pending_valid_ff, pending_valid_in;
   logic [OFFSET_W-1:0] pending_begin_ff, pending_begin_in;
   logic [OFFSET_W-1:0] pos_ff, pos_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                stopped_ff, stopped_in;

   // Request decode
   logic             req_accept;
   req_kind_type     kind;
   logic             is_load, is_doc, is_end;
   logic [LEN_W-1:0] len_eff;
   logic             byte_cont;
   logic             decide, limit_hit, acc_doc, stop_doc, stop_end, emit_end;
   logic             top_hit;

   cell_bus_type         bus;
   logic [MAX_QUERY_BYTES-1:0] prefix_bit;
   logic [MAX_QUERY_BYTES-1:0] prefix_next;
   logic [MAX_QUERY_BYTES-1:0] full_hit;

   push_type   push;
   result_type head;
   logic       q_not_empty, q_has_room;
   result_type match_word, summary_word;

   // APB register access
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_reg   = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff  <= '0;
         limit_ff <= MATCH_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_reg)
            REG_QUERY_LENGTH: qlen_ff  <= pwdata[LEN_W-1:0];
            REG_MATCH_LIMIT:  limit_ff <= pwdata[COUNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_QUERY_LENGTH: prdata = CSR_DATA_W'(qlen_ff);
         REG_MATCH_LIMIT:  prdata = CSR_DATA_W'(limit_ff);
      endcase
   end

   // Decode
   assign req_accept = req_if.valid && req_if.ready;
   assign kind       = req_kind_type'(req_if.req_type);
   assign is_load    = req_accept && (kind == REQ_LOAD);
   assign is_doc     = req_accept && (kind == REQ_DOC);
   assign is_end     = req_accept && (kind == REQ_END);
   assign len_eff    = (qlen_ff > LEN_W'(MAX_QUERY_BYTES)) ? '0 : qlen_ff;
   assign byte_cont  = is_cont(req_if.data_byte);

   // Pending-match decision
   assign decide    = !stopped_ff && pending_valid_ff;
   assign limit_hit = count_ff == limit_ff;
   assign acc_doc   = decide && !byte_cont;
   assign stop_doc  = stopped_ff || (acc_doc && limit_hit);
   assign stop_end  = stopped_ff || (decide && limit_hit);
   assign emit_end  = decide && !limit_hit;

   // Cell row control
   assign bus.load       = is_load;
   assign bus.load_index = req_if.query_index;
   assign bus.load_byte  = req_if.data_byte;
   assign bus.step       = is_doc && !stop_doc;
   assign bus.flush      = is_doc && acc_doc && !limit_hit;
   assign bus.clear      = is_end || (is_doc && acc_doc && limit_hit);
   assign bus.doc_folded = fold_byte(req_if.data_byte);
   assign bus.start      = !((pos_ff != '0) && byte_cont);
   assign bus.len        = len_eff;

   // Row of cells; prefix bits shift one position per document byte
   for (genvar i = 0; i < MAX_QUERY_BYTES; i++) begin : g_cell
      logic chain;
      if (i == 0) begin : g_first
         assign chain = bus.start;
      end else begin : g_rest
         assign chain = prefix_bit[i-1] & ~bus.flush;
      end
      fss_cell #(.CELL_INDEX(i)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .bus         (bus),
         .chain_in    (chain),
         .prefix_out  (prefix_bit[i]),
         .prefix_next (prefix_next[i])
      );
      assign full_hit[i] = prefix_next[i] && (len_eff == LEN_W'(i + 1));
   end

   assign top_hit = |full_hit;

   // Result words
   always_comb begin
      match_word.match_start = pending_begin_ff;
      match_word.match_end   = pending_begin_ff + OFFSET_W'(len_eff);
      match_word.is_summary  = 1'b0;
      match_word.truncated   = 1'b0;
      match_word.match_total = count_ff + 1'b1;
      match_word.last_result = 1'b0;

      summary_word.match_start = '0;
      summary_word.match_end   = '0;
      summary_word.is_summary  = 1'b1;
      summary_word.truncated   = stop_end;
      summary_word.match_total = emit_end ? (count_ff + 1'b1) : count_ff;
      summary_word.last_result = 1'b1;
   end

   // Next search state and queue pushes
   always_comb begin
      pending_valid_in = pending_valid_ff;
      pending_begin_in = pending_begin_ff;
      pos_in           = pos_ff;
      count_in         = count_ff;
      stopped_in       = stopped_ff;
      push.count       = 2'd0;
      push.w0          = summary_word;
      push.w1          = summary_word;

      if (is_doc) begin
         if (decide) begin
            pending_valid_in = 1'b0;
         end
         if (acc_doc) begin
            if (limit_hit) begin
               stopped_in = 1'b1;
            end else begin
               count_in               = count_ff + 1'b1;
               push.count             = 2'd1;
               push.w0                = match_word;
               push.w0.last_result    = 1'b1;
            end
         end
         if (!stop_doc && top_hit) begin
            pending_valid_in = 1'b1;
            pending_begin_in = pos_ff - OFFSET_W'(len_eff - 1'b1);
         end
         pos_in = pos_ff + 1'b1;
      end else if (is_end) begin
         if (emit_end) begin
            push.count = 2'd2;
            push.w0    = match_word;
         end else begin
            push.count = 2'd1;
         end
         pending_valid_in = 1'b0;
         pending_begin_in = '0;
         pos_in           = '0;
         count_in         = '0;
         stopped_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff <= 1'b0;
         pending_begin_ff <= '0;
         pos_ff           <= '0;
         count_ff         <= '0;
         stopped_ff       <= 1'b0;
      end else begin
         pending_valid_ff <= pending_valid_in;
         pending_begin_ff <= pending_begin_in;
         pos_ff           <= pos_in;
         count_ff         <= count_in;
         stopped_ff       <= stopped_in;
      end
   end

   // Result queue
   fss_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .pop       (rsp_if.valid && rsp_if.ready),
      .head      (head),
      .not_empty (q_not_empty),
      .has_room  (q_has_room)
   );

   assign req_if.ready       = q_has_room;
   assign rsp_if.valid       = q_not_empty;
   assign rsp_if.match_start = head.match_start;
   assign rsp_if.match_end   = head.match_end;
   assign rsp_if.is_summary  = head.is_summary;
   assign rsp_if.truncated   = head.truncated;
   assign rsp_if.match_total = head.match_total;
   assign rsp_if.last_result = head.last_result;

endmodule

`default_nettype wire

FILE: src/fss_checker.sv
// Port-level checks on the folded substring search, bound to the top level.
// Depends on fss_pkg and folded_substring_search_top_macros.svh.
`default_nettype none

`include "folded_substring_search_top_macros.svh"

module fss_checker import fss_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [OFFSET_W-1:0] match_start,
   input wire logic [OFFSET_W-1:0] match_end,
   input wire logic                is_summary,
   input wire logic                truncated,
   input wire logic [COUNT_W-1:0]  match_total,
   input wire logic                last_result
);

   // A stalled result word holds its start, end and total
   `FSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(match_start) && $stable(match_end) && $stable(match_total), "result word changed while stalled")

   // The summary always closes its request
   `FSS_ASSERT_NOW(a_summary_last, rsp_valid && is_summary, last_result, "summary without last_result")

   // Match reports never carry truncated or a zero count
   `FSS_ASSERT_NOW(a_report_clean, rsp_valid && !is_summary, !truncated && (match_total != '0), "bad match report flags")

   // Reset empties the result queue
   `FSS_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result valid after reset")

endmodule

bind folded_substring_search_top fss_checker u_fss_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .match_start (rsp_if.match_start),
   .match_end   (rsp_if.match_end),
   .is_summary  (rsp_if.is_summary),
   .truncated   (rsp_if.truncated),
   .match_total (rsp_if.match_total),
   .last_result (rsp_if.last_result)
);

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for folded_substring_search_top: directed cases and random documents.
// Uses fss_pkg, the fss_req_if and fss_rsp_if interfaces and the RTL under src.
`timescale 1ns / 1ps

module tb_top;
   import fss_pkg::*;

   // Request type with no meaning; the block drops it
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1350;

   typedef struct packed {
      logic [1:0]        kind;
      logic [QIDX_W-1:0] index;
      logic [7:0]        value;
   } req_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   fss_req_if req_if ();
   fss_rsp_if rsp_if ();

   folded_substring_search_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Words waiting for the driver, and search results still owed by the block
   req_word_type pending_words[$];
   result_type   due_results[$];
   req_word_type outgoing;
   logic       req_fired = 1'b0;
   int         words_queued = 0;
   int         words_taken  = 0;
   int         items_queued = 0;
   int         mismatches   = 0;
   int         send_gap_pct   = 0;
   int         recv_stall_pct = 0;

   // Shadow of the search state, updated per accepted word
   logic [7:0]         query_bytes [MAX_QUERY_BYTES_DEFAULT];
   logic [63:0]        live_prefixes    = '0;
   logic               pending_hit      = 1'b0;
   logic [OFFSET_W-1:0] pending_start   = '0;
   logic [OFFSET_W-1:0] doc_offset      = '0;
   logic [COUNT_W-1:0] kept_matches     = '0;
   logic               halted           = 1'b0;
   logic [LEN_W-1:0]   cfg_query_length = '0;
   logic [COUNT_W-1:0] cfg_match_limit  = MATCH_LIMIT_RESET;

   // Query as the stimulus side last wrote it; used only to build documents
   logic [7:0] plan_bytes [MAX_QUERY_BYTES_DEFAULT];
   int         plan_length = 0;

   function automatic logic [7:0] lower_ascii(logic [7:0] b);
      if (b >= "A" && b <= "Z") begin
         return b | 8'h20;
      end
      return b;
   endfunction

   function automatic logic is_trailing(logic [7:0] b);
      return b >= 8'h80 && b <= 8'hBF;
   endfunction

   // Lengths above the cell row count disable matching like zero does
   function automatic int active_length();
      if (cfg_query_length == 0 || cfg_query_length > MAX_QUERY_BYTES_DEFAULT) begin
         return 0;
      end
      return int'(cfg_query_length);
   endfunction

   function automatic void queue_result(logic [OFFSET_W-1:0] first, logic [OFFSET_W-1:0] past,
                                        logic summary, logic cut);
      result_type r;
      r.match_start = first;
      r.match_end   = past;
      r.is_summary  = summary;
      r.truncated   = cut;
      r.match_total = kept_matches;
      r.last_result = 1'b0;
      due_results = {due_results, r};
   endfunction

   // Settle the pending match; at the limit it stops the search instead
   function automatic void close_match();
      pending_hit   = 1'b0;
      live_prefixes = '0;
      if (kept_matches == cfg_match_limit) begin
         halted = 1'b1;
      end else begin
         kept_matches++;
         queue_result(pending_start, pending_start + OFFSET_W'(active_length()), 1'b0, 1'b0);
      end
   endfunction

   function automatic void search_step(logic [1:0] kind, logic [QIDX_W-1:0] index,
                                       logic [7:0] value);
      int         owed_before;
      int         len;
      int         i;
      logic [63:0] hit;
      logic [63:0] len_mask;
      logic       seed_bit;
      result_type tail;
      owed_before = due_results.size();
      case (kind)
         REQ_LOAD: query_bytes[index] = value;
         REQ_DOC: begin
            // the byte after a full match decides it
            if (!halted && pending_hit) begin
               if (is_trailing(value)) begin
                  pending_hit = 1'b0;
               end else begin
                  close_match();
               end
            end
            if (!halted) begin
               len = active_length();
               if (len != 0) begin
                  hit = '0;
                  for (i = 0; i < len; i++) begin
                     if (lower_ascii(query_bytes[i]) == lower_ascii(value)) begin
                        hit[i] = 1'b1;
                     end
                  end
                  len_mask = (len == 64) ? '1 : ((64'd1 << len) - 64'd1);
                  // no candidate may start on a continuation byte past offset zero
                  seed_bit = !(doc_offset != 0 && is_trailing(value));
                  live_prefixes = ((live_prefixes << 1) | {63'd0, seed_bit}) & hit & len_mask;
                  if (live_prefixes[len-1]) begin
                     pending_hit   = 1'b1;
                     pending_start = doc_offset - OFFSET_W'(len - 1);
                  end
               end else begin
                  live_prefixes = '0;
               end
            end
            doc_offset++;
         end
         REQ_END: begin
            if (!halted && pending_hit) begin
               close_match();
            end
            pending_hit = 1'b0;
            queue_result('0, '0, 1'b1, halted);
            live_prefixes = '0;
            pending_start = '0;
            doc_offset    = '0;
            kept_matches  = '0;
            halted        = 1'b0;
         end
         default: ;
      endcase
      // flag the final word of this request
      if (due_results.size() > owed_before) begin
         tail = due_results[$];
         tail.last_result = 1'b1;
         due_results[due_results.size() - 1] = tail;
      end
   endfunction

   function automatic void note_mismatch(string what, result_type want, result_type seen);
      if (mismatches < 10) begin
         $display("%s (start end summary truncated total last): want %0d %0d %b %b %0d %b,",
                  what, want.match_start, want.match_end, want.is_summary, want.truncated,
                  want.match_total, want.last_result);
         $display("   got %0d %0d %b %b %0d %b", seen.match_start, seen.match_end,
                  seen.is_summary, seen.truncated, seen.match_total, seen.last_result);
      end
      mismatches++;
   endfunction

   // Monitor: predict on every accepted request word, check every accepted result word
   result_type seen_word;
   result_type want_word;
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            search_step(req_if.req_type, req_if.query_index, req_if.data_byte);
            words_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen_word.match_start = rsp_if.match_start;
            seen_word.match_end   = rsp_if.match_end;
            seen_word.is_summary  = rsp_if.is_summary;
            seen_word.truncated   = rsp_if.truncated;
            seen_word.match_total = rsp_if.match_total;
            seen_word.last_result = rsp_if.last_result;
            if (due_results.size() == 0) begin
               note_mismatch("unexpected result", '0, seen_word);
            end else begin
               want_word = due_results.pop_front();
               if (seen_word.match_start !== want_word.match_start ||
                   seen_word.match_end   !== want_word.match_end   ||
                   seen_word.is_summary  !== want_word.is_summary  ||
                   seen_word.truncated   !== want_word.truncated   ||
                   seen_word.match_total !== want_word.match_total ||
                   seen_word.last_result !== want_word.last_result) begin
                  note_mismatch("result mismatch", want_word, seen_word);
               end
            end
         end
      end
   end

   // Driver: hold a word until taken, then fetch the next one or leave a gap
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fired) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            outgoing = pending_words.pop_front();
            req_if.valid       <= 1'b1;
            req_if.req_type    <= outgoing.kind;
            req_if.query_index <= outgoing.index;
            req_if.data_byte   <= outgoing.value;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver stalls
   always @(negedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic push_word(logic [1:0] kind, logic [QIDX_W-1:0] index, logic [7:0] value);
      req_word_type w;
      w.kind  = kind;
      w.index = index;
      w.value = value;
      pending_words = {pending_words, w};
      words_queued++;
      if (kind != REQ_UNUSED) begin
         items_queued++;
      end
   endtask

   task automatic push_load(int index, logic [7:0] value);
      plan_bytes[index] = value;
      push_word(REQ_LOAD, QIDX_W'(index), value);
   endtask

   task automatic push_doc(logic [7:0] value);
      push_word(REQ_DOC, QIDX_W'($urandom_range(63)), value);
   endtask

   task automatic push_end();
      push_word(REQ_END, QIDX_W'($urandom_range(63)), 8'($urandom_range(255)));
   endtask

   task automatic push_noise();
      push_word(REQ_UNUSED, QIDX_W'($urandom_range(63)), 8'($urandom_range(255)));
   endtask

   // Block idle: every word taken, every result seen
   task automatic wait_idle();
      while (words_taken != words_queued || due_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(reg_index_type which, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(which));
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (which == REG_QUERY_LENGTH) begin
         cfg_query_length = value[LEN_W-1:0];
      end else begin
         cfg_match_limit = value[COUNT_W-1:0];
      end
   endtask

   task automatic set_length(int value);
      wait_idle();
      csr_write(REG_QUERY_LENGTH, CSR_DATA_W'(value));
      plan_length = (value == 0 || value > MAX_QUERY_BYTES_DEFAULT) ? 0 : value;
   endtask

   function automatic logic [7:0] flip_case(logic [7:0] b);
      if (((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) && $urandom_range(1) == 1) begin
         return b ^ 8'h20;
      end
      return b;
   endfunction

   // Query bytes from a small alphabet so that repeats and overlaps are common
   function automatic logic [7:0] query_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) return "a" + 8'($urandom_range(1));
      if (pick < 50) return "A" + 8'($urandom_range(1));
      if (pick < 62) return 8'($urandom_range(191, 128));
      if (pick < 70) return 8'hC3;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] filler_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35 && plan_length > 0) return flip_case(plan_bytes[$urandom_range(plan_length - 1)]);
      if (pick < 55) return flip_case("a" + 8'($urandom_range(2)));
      if (pick < 70) return 8'($urandom_range(191, 128));
      return 8'($urandom_range(255));
   endfunction

   function automatic int pick_length();
      int pick;
      pick = $urandom_range(19);
      if (pick == 0) return 0;
      if (pick == 1) return MAX_QUERY_BYTES_DEFAULT;
      if (pick == 2) return int'($urandom_range(127, 65));
      if (pick == 3) return int'($urandom_range(63, 7));
      return int'($urandom_range(6, 1));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_limit();
      case ($urandom_range(7))
         0: return 0;
         1: return 1;
         2: return 2;
         3: return 65535;
         4: return 1024;
         default: return CSR_DATA_W'($urandom_range(12, 3));
      endcase
   endfunction

   // One document: query copies with random case, filler, continuation bytes, noise, query byte loads, length changes
   task automatic queue_document();
      int segments;
      int pick;
      int span;
      int i;
      int k;
      int new_len;
      segments = $urandom_range(8, 1);
      for (k = 0; k < segments; k++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            span = plan_length;
            if (span > 0 && $urandom_range(4) == 0) begin
               span = $urandom_range(span, 1);
            end
            if (span == 0) begin
               span = $urandom_range(3, 1);
            end
            for (i = 0; i < span; i++) begin
               push_doc(plan_length > 0 ? flip_case(plan_bytes[i]) : filler_byte());
            end
            // change the query length (shorter, zero or out of range) right after a possible full match
            if (plan_length > 0 && $urandom_range(15) == 0) begin
               case ($urandom_range(3))
                  0: new_len = 0;
                  1: new_len = 127;
                  default: new_len = $urandom_range(plan_length, 1);
               endcase
               set_length(new_len);
            end
         end else if (pick < 70) begin
            repeat ($urandom_range(6, 1)) push_doc(filler_byte());
         end else if (pick < 85) begin
            push_doc(8'($urandom_range(191, 128)));
         end else if (pick < 92) begin
            push_noise();
         end else begin
            push_load($urandom_range(63), query_byte());
         end
      end
      push_end();
   endtask

   initial begin : stimulus
      int random_base;
      int progress;
      int length;
      int eff;
      int i;
      bit first_phase;
      req_if.valid       = 1'b0;
      req_if.req_type    = REQ_DOC;
      req_if.query_index = '0;
      req_if.data_byte   = '0;
      rsp_if.ready       = 1'b0;
      foreach (plan_bytes[j]) plan_bytes[j] = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_gap_pct   = 29;
      recv_stall_pct = 79;

      // Reset length is zero: no matches, only a summary; unknown type dropped
      push_doc("a");
      push_word(REQ_UNUSED, 6'd63, 8'hFF);
      push_end();
      push_load(0, "A");
      push_load(1, "b");
      push_load(63, 8'hFF);
      set_length(2);
      // continuation after the match rejects it; plain byte accepts; end accepts pending
      push_doc("a");
      push_doc("B");
      push_doc(8'h80);
      push_doc("a");
      push_doc("b");
      push_doc("x");
      push_doc("A");
      push_doc("B");
      push_end();
      // continuation start byte: allowed at offset zero, rejected later
      push_load(0, 8'h80);
      push_doc(8'h80);
      push_doc("b");
      push_end();
      push_doc("x");
      push_doc(8'h80);
      push_doc("b");
      push_end();
      // limit of zero: the first match truncates
      wait_idle();
      csr_write(REG_MATCH_LIMIT, 0);
      push_doc(8'h80);
      push_doc("b");
      push_end();

      // Random phases: new query, new settings, a few documents each
      random_base = items_queued;
      first_phase = 1'b1;
      while (items_queued < random_base + RANDOM_ITEMS) begin
         progress = items_queued - random_base;
         if (progress < RANDOM_ITEMS / 3) begin
            send_gap_pct   = 29;
            recv_stall_pct = 79;
         end else if (progress < 2 * RANDOM_ITEMS / 3) begin
            send_gap_pct   = 79;
            recv_stall_pct = 29;
         end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         length = pick_length();
         eff = (length > MAX_QUERY_BYTES_DEFAULT) ? 0 : length;
         for (i = 0; i < eff; i++) begin
            push_load(i, query_byte());
         end
         if (eff == 0) begin
            push_load($urandom_range(63), query_byte());
         end
         set_length(length);
         if (first_phase || $urandom_range(1) == 1) begin
            csr_write(REG_MATCH_LIMIT, pick_limit());
         end
         first_phase = 1'b0;
         repeat ($urandom_range(3, 1)) queue_document();
      end

      wait_idle();
      repeat (5) @(negedge clock);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("[folded_substring_search_top] OK");
      end else begin
         $display("[folded_substring_search_top] ERROR");
      end
      $finish;
   end

   // Run limit
   initial begin
      #400000;
      $display("[folded_substring_search_top] ERROR");
      $finish;
   end

endmodule
